@@ rtl/y2r_pkg.sv @@
// Shared types and constants for the YUYV 4:2:2 to RGB888 converter.
// Used by y2r_chroma, y2r_lane and yuyv_to_rgb888_converter; depends on nothing.
package y2r_pkg;

   localparam int BYTE_W = 8;
   localparam int PROD_W = 18;                 // holds 443 * -128 with sign
   localparam int TERM_W = PROD_W - BYTE_W;    // chroma term after the >>> 8
   localparam int SUM_W  = TERM_W + 1;         // luma plus term, signed

   localparam logic signed [PROD_W-1:0] K_BU = PROD_W'(443);
   localparam logic signed [PROD_W-1:0] K_GV = PROD_W'(179);
   localparam logic signed [PROD_W-1:0] K_GU = PROD_W'(86);
   localparam logic signed [PROD_W-1:0] K_RV = PROD_W'(351);

   localparam logic [BYTE_W-1:0] CH_MAX = 8'd255;

   typedef struct packed {
      logic [BYTE_W-1:0] luma_first;
      logic [BYTE_W-1:0] chroma_blue;
      logic [BYTE_W-1:0] luma_second;
      logic [BYTE_W-1:0] chroma_red;
      logic              frame_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red_first;
      logic [BYTE_W-1:0] green_first;
      logic [BYTE_W-1:0] blue_first;
      logic [BYTE_W-1:0] red_second;
      logic [BYTE_W-1:0] green_second;
      logic [BYTE_W-1:0] blue_second;
      logic              frame_end_out;
   } rsp_type;

   // Shared chroma terms for one pixel pair, already shifted.
   typedef struct packed {
      logic signed [TERM_W-1:0] bterm;
      logic signed [TERM_W-1:0] gterm;
      logic signed [TERM_W-1:0] rterm;
   } term_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] luma_first;
      logic [BYTE_W-1:0] luma_second;
      logic              frame_end;
      term_type          terms;
   } stage_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } pixel_type;

endpackage

@@ rtl/y2r_chroma.sv @@
// Shared chroma unit: constant products, then the summed and shifted terms.
// Depends on y2r_pkg.
module y2r_chroma (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  y2r_pkg::req_type    in_req,
   output y2r_pkg::stage_type  out_stage
);
   import y2r_pkg::*;

   logic signed [PROD_W-1:0] du;
   logic signed [PROD_W-1:0] dv;

   logic signed [PROD_W-1:0] p_bu_ff, p_gv_ff, p_gu_ff, p_rv_ff;
   logic signed [PROD_W-1:0] p_bu_in, p_gv_in, p_gu_in, p_rv_in;
   logic                     valid1_ff;
   logic [BYTE_W-1:0]        luma0_ff, luma1_ff;
   logic                     fend1_ff;

   logic signed [PROD_W-1:0] g_sum;
   stage_type                stage_ff, stage_in;

   // Remove the 128 offset: flipping the top bit gives the signed byte.
   assign du = PROD_W'($signed({~in_req.chroma_blue[BYTE_W-1],
                                 in_req.chroma_blue[BYTE_W-2:0]}));
   assign dv = PROD_W'($signed({~in_req.chroma_red[BYTE_W-1],
                                 in_req.chroma_red[BYTE_W-2:0]}));

   assign p_bu_in = du * K_BU;
   assign p_gv_in = dv * K_GV;
   assign p_gu_in = du * K_GU;
   assign p_rv_in = dv * K_RV;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      p_bu_ff  <= p_bu_in;
      p_gv_ff  <= p_gv_in;
      p_gu_ff  <= p_gu_in;
      p_rv_ff  <= p_rv_in;
      luma0_ff <= in_req.luma_first;
      luma1_ff <= in_req.luma_second;
      fend1_ff <= in_req.frame_end;
   end

   assign g_sum = p_gv_ff + p_gu_ff;

   // Arithmetic shift by 8: keep the upper bits, which floors the quotient.
   always_comb begin
      stage_in.valid       = valid1_ff;
      stage_in.luma_first  = luma0_ff;
      stage_in.luma_second = luma1_ff;
      stage_in.frame_end   = fend1_ff;
      stage_in.terms.bterm = p_bu_ff[PROD_W-1:BYTE_W];
      stage_in.terms.gterm = g_sum[PROD_W-1:BYTE_W];
      stage_in.terms.rterm = p_rv_ff[PROD_W-1:BYTE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.luma_first  <= stage_in.luma_first;
      stage_ff.luma_second <= stage_in.luma_second;
      stage_ff.frame_end   <= stage_in.frame_end;
      stage_ff.terms       <= stage_in.terms;
   end

   assign out_stage = stage_ff;

endmodule

@@ rtl/y2r_lane.sv @@
// One pixel lane: add luma to the shared chroma terms and clamp each channel.
// Depends on y2r_pkg.
module y2r_lane (
   input  logic [y2r_pkg::BYTE_W-1:0] luma,
   input  y2r_pkg::term_type          terms,
   output y2r_pkg::pixel_type         pixel
);
   import y2r_pkg::*;

   logic signed [SUM_W-1:0] y_ext;
   logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;

   function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] x);
      logic [BYTE_W-1:0] res;
      if (x < 0) begin
         res = '0;
      end else if (x > $signed(SUM_W'(CH_MAX))) begin
         res = CH_MAX;
      end else begin
         res = x[BYTE_W-1:0];
      end
      return res;
   endfunction

   assign y_ext = $signed(SUM_W'(luma));
   assign r_sum = y_ext + SUM_W'(terms.rterm);
   assign g_sum = y_ext - SUM_W'(terms.gterm);
   assign b_sum = y_ext + SUM_W'(terms.bterm);

   always_comb begin
      pixel.red   = clamp_byte(r_sum);
      pixel.green = clamp_byte(g_sum);
      pixel.blue  = clamp_byte(b_sum);
   end

endmodule

@@ rtl/yuyv_to_rgb888_converter.sv @@
// Top level of the YUYV 4:2:2 to RGB888 converter: chroma unit, two pixel lanes, merge.
// Depends on y2r_pkg, y2r_chroma and y2r_lane.

// Converts one packed YUYV word (Y0, U, Y1, V) into two RGB888 pixels that
// share the chroma. A request is taken on every clock edge where start is
// high; busy never rises, so a new word may follow in the very next cycle
// and the sustained rate is one request per clock. The result passes through
// the constant-product register, the shifted-term register and the output
// register before it appears, and rsp_valid is high for exactly one
// cycle. The receiver cannot stall the block, so it must take every result
// in the cycle it is shown. Results leave in request order; frame_end passes
// through unchanged alongside its pixel pair.
module yuyv_to_rgb888_converter (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  y2r_pkg::req_type  req_payload,
   output logic              rsp_valid,
   output y2r_pkg::rsp_type  rsp_payload
);
   import y2r_pkg::*;

   stage_type  stage;
   pixel_type  pix_first, pix_second;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff;
   logic       req_take;

   // The pipeline never backs up, so hold busy low.
   assign busy     = 1'b0;
   assign req_take = start & ~busy;

   // Shared chroma terms for both pixels of the pair.
   y2r_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_req    (req_payload),
      .out_stage (stage)
   );

   // Two lanes side by side, one per luma sample.
   y2r_lane u_lane_first (
      .luma  (stage.luma_first),
      .terms (stage.terms),
      .pixel (pix_first)
   );

   y2r_lane u_lane_second (
      .luma  (stage.luma_second),
      .terms (stage.terms),
      .pixel (pix_second)
   );

   // Merge the lanes into one result word.
   always_comb begin
      rsp_in.red_first     = pix_first.red;
      rsp_in.green_first   = pix_first.green;
      rsp_in.blue_first    = pix_first.blue;
      rsp_in.red_second    = pix_second.red;
      rsp_in.green_second  = pix_second.green;
      rsp_in.blue_second   = pix_second.blue;
      rsp_in.frame_end_out = stage.frame_end;
   end

   // Register the result; advance the strobe with it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
